@@ hdl/sapq_pkg.sv @@
`timescale 1ns / 1ps
// sapq_pkg: types and codes for the sorted-array priority queue
// no dependencies; used by sapq_cell and sorted_array_priority_queue

package sapq_pkg;

    localparam int CAPACITY_DEF = 8;
    localparam int KEY_W        = 32;
    localparam int FILL_W       = 4;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_REMOVE = 1'b1;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2
    } t_status;

    typedef struct packed {
        logic                    command;
        logic signed [KEY_W-1:0] value;
    } t_in;

    typedef struct packed {
        logic signed [KEY_W-1:0] removed_value;
        t_status                 status;
        logic [FILL_W-1:0]       fill_count;
        logic                    is_empty;
        logic                    is_full;
    } t_out;

    // operation broadcast to every cell of the chain
    typedef struct packed {
        logic ins;
        logic rem;
    } t_cell_ctrl;

endpackage

@@ hdl/sapq_cell.sv @@
`timescale 1ns / 1ps
// sapq_cell: one slot of the sorted chain, holds a key and talks to its neighbours
// depends on sapq_pkg

module sapq_cell (
    input  logic                             i_clk,
    input  sapq_pkg::t_cell_ctrl             i_ctrl,
    input  logic signed [sapq_pkg::KEY_W-1:0] i_key,
    input  logic                             i_occ,
    input  logic                             i_left_occ,
    input  logic                             i_left_gt,
    input  logic signed [sapq_pkg::KEY_W-1:0] i_left_data,
    input  logic signed [sapq_pkg::KEY_W-1:0] i_right_data,
    output logic signed [sapq_pkg::KEY_W-1:0] o_data,
    output logic                             o_gt
);

    logic signed [sapq_pkg::KEY_W-1:0] r_data;
    logic signed [sapq_pkg::KEY_W-1:0] n_data;
    logic                              w_take;

    // strict compare keeps equal keys ahead of the new one
    assign o_gt   = i_occ && (i_key < r_data);
    // first free slot takes part in the insert too
    assign w_take = o_gt || (!i_occ && i_left_occ);
    assign o_data = r_data;

    always_comb begin
        n_data = r_data;
        if (i_ctrl.ins && w_take) begin
            n_data = i_left_gt ? i_left_data : i_key;
        end else if (i_ctrl.rem) begin
            n_data = i_right_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

endmodule

@@ hdl/sorted_array_priority_queue.sv @@
`timescale 1ns / 1ps
// sorted_array_priority_queue: min-first priority queue on a chain of sorted cells
// depends on sapq_pkg and sapq_cell
//
// channel   valid        ready         payload
// input     i_in_valid   o_in_ready    i_in_data  (sapq_pkg::t_in)
// output    o_out_valid  i_out_ready   o_out_data (sapq_pkg::t_out)
//
// one item per cycle while the output does not stall: every cell compares
// against the key at once and the whole chain updates at the accepting edge,
// as does the output register that holds the result. reset clears the count
// and the output valid only. a stalled output holds the input back only while
// its register is full and not being taken.

module sorted_array_priority_queue #(
    parameter int CAPACITY = sapq_pkg::CAPACITY_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  sapq_pkg::t_in   i_in_data,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output sapq_pkg::t_out  o_out_data
);

    localparam int CW = $clog2(CAPACITY + 1);

    logic [CW-1:0]                     r_count;
    logic [CW-1:0]                     n_count;
    logic                              r_out_valid;
    sapq_pkg::t_out                    r_out;
    sapq_pkg::t_out                    n_out;
    sapq_pkg::t_cell_ctrl              w_ctrl;
    logic                              w_accept;
    logic                              w_full;
    logic                              w_empty;
    logic signed [sapq_pkg::KEY_W-1:0] w_data [CAPACITY];
    logic                              w_gt   [CAPACITY];
    logic                              w_occ  [CAPACITY];

    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign w_accept    = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign w_full  = (r_count == CW'(CAPACITY));
    assign w_empty = (r_count == '0);

    assign w_ctrl.ins = w_accept && (i_in_data.command == sapq_pkg::CMD_INSERT) && !w_full;
    assign w_ctrl.rem = w_accept && (i_in_data.command == sapq_pkg::CMD_REMOVE) && !w_empty;

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            assign w_occ[g] = (CW'(g) < r_count);

            if (g == 0) begin : g_head
                sapq_cell u_cell (
                    .i_clk        (i_clk),
                    .i_ctrl       (w_ctrl),
                    .i_key        (i_in_data.value),
                    .i_occ        (w_occ[g]),
                    .i_left_occ   (1'b1),
                    .i_left_gt    (1'b0),
                    .i_left_data  ('0),
                    .i_right_data (w_data[g+1]),
                    .o_data       (w_data[g]),
                    .o_gt         (w_gt[g])
                );
            end else if (g == CAPACITY - 1) begin : g_tail
                sapq_cell u_cell (
                    .i_clk        (i_clk),
                    .i_ctrl       (w_ctrl),
                    .i_key        (i_in_data.value),
                    .i_occ        (w_occ[g]),
                    .i_left_occ   (w_occ[g-1]),
                    .i_left_gt    (w_gt[g-1]),
                    .i_left_data  (w_data[g-1]),
                    .i_right_data ('0),
                    .o_data       (w_data[g]),
                    .o_gt         (w_gt[g])
                );
            end else begin : g_mid
                sapq_cell u_cell (
                    .i_clk        (i_clk),
                    .i_ctrl       (w_ctrl),
                    .i_key        (i_in_data.value),
                    .i_occ        (w_occ[g]),
                    .i_left_occ   (w_occ[g-1]),
                    .i_left_gt    (w_gt[g-1]),
                    .i_left_data  (w_data[g-1]),
                    .i_right_data (w_data[g+1]),
                    .o_data       (w_data[g]),
                    .o_gt         (w_gt[g])
                );
            end
        end
    endgenerate

    always_comb begin
        n_count = r_count;
        if (w_ctrl.ins) begin
            n_count = r_count + CW'(1);
        end else if (w_ctrl.rem) begin
            n_count = r_count - CW'(1);
        end

        n_out               = '0;
        n_out.status        = sapq_pkg::ST_OK;
        if (i_in_data.command == sapq_pkg::CMD_INSERT) begin
            if (w_full) begin
                n_out.status = sapq_pkg::ST_OVERFLOW;
            end
        end else begin
            if (w_empty) begin
                n_out.status = sapq_pkg::ST_UNDERFLOW;
            end else begin
                n_out.removed_value = w_data[0];
            end
        end
        // count after the operation, masked to the field width
        n_out.fill_count = sapq_pkg::FILL_W'(n_count);
        n_out.is_empty   = (n_count == '0);
        n_out.is_full    = (n_count == CW'(CAPACITY));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (w_accept) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (w_accept) begin
            r_out <= n_out;
        end
    end

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("count beyond capacity");

    a_count_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_accept |=> $stable(r_count))
        else $error("count moved without an item");

    a_overflow_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.status == sapq_pkg::ST_OVERFLOW) |-> o_out_data.is_full)
        else $error("overflow reported while not full");

    a_underflow_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.status == sapq_pkg::ST_UNDERFLOW) |-> o_out_data.is_empty)
        else $error("underflow reported while not empty");

endmodule
